FILE: src/tcgr_pkg.sv
// Shared types, codes and constants for the text console glyph renderer.
`timescale 1ns / 1ps

package tcgr_pkg;

    localparam int COLUMN_W   = 7;
    localparam int LINE_W     = 6;
    localparam int ADDR_W     = 19;
    localparam int PIXELS_W   = 64;
    localparam int GLYPH_W    = 7;
    localparam int ROW_W      = 3;
    localparam int FONT_AW    = 10;
    localparam int FONT_DEPTH = 760;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [GLYPH_W-1:0] GLYPH_COUNT = 7'd95;
    localparam logic [STEP_W-1:0]  ROW_LAST_STEP = 4'd7;
    localparam logic [STEP_W-1:0]  SCROLL_STEP   = 4'd8;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FONT  = 2'd2;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SCROLL = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

    localparam logic [7:0] FG_RESET = 8'd15;
    localparam logic [7:0] BG_RESET = 8'd0;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_SUBST = 8'h3F;

    typedef enum logic [2:0] {
        CMD_DRAW,
        CMD_ERASE,
        CMD_SCROLL,
        CMD_CLEAR,
        CMD_FONT
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [GLYPH_W-1:0] glyph;
        logic [ROW_W-1:0]   row;
        logic [7:0]         bits;
        logic [ADDR_W-1:0]  base;
        logic               scroll;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

endpackage

FILE: src/tcgr_ifs.sv
// Channel interfaces for items, results and register writes.
`timescale 1ns / 1ps

interface tcgr_item_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [7:0]                     char_code;
    logic [tcgr_pkg::GLYPH_W-1:0]   glyph_index;
    logic [tcgr_pkg::ROW_W-1:0]     glyph_row;
    logic [7:0]                     glyph_bits;

    modport source (output valid, kind, char_code, glyph_index, glyph_row, glyph_bits,
                    input ready);
    modport sink (input valid, kind, char_code, glyph_index, glyph_row, glyph_bits,
                  output ready);
endinterface

interface tcgr_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     op;
    logic [tcgr_pkg::ADDR_W-1:0]    pixel_address;
    logic [tcgr_pkg::PIXELS_W-1:0]  pixels;
    logic                           last;

    modport source (output valid, op, pixel_address, pixels, last, input ready);
    modport sink (input valid, op, pixel_address, pixels, last, output ready);
endinterface

interface tcgr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tcgr_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tcgr_front.sv
// Front end: accepts items, keeps the text cursor and turns items into commands.
`timescale 1ns / 1ps

module tcgr_front #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_LINES   = 60,
    parameter int LINE_PIXELS  = 640
) (
    input  logic              clk,
    input  logic              rst_n,
    tcgr_item_if.sink         item,
    input  logic              q_full,
    output logic              push,
    output tcgr_pkg::qentry_t push_entry
);

    localparam int ROW_STRIDE = 8 * LINE_PIXELS;

    logic [tcgr_pkg::COLUMN_W-1:0] col_reg;
    logic [tcgr_pkg::COLUMN_W-1:0] col_next;
    logic [tcgr_pkg::LINE_W-1:0]   line_reg;
    logic [tcgr_pkg::LINE_W-1:0]   line_next;
    logic [tcgr_pkg::COLUMN_W:0]   col_inc;
    logic [tcgr_pkg::LINE_W:0]     line_inc;
    logic [tcgr_pkg::COLUMN_W-1:0] col_dec;
    logic [tcgr_pkg::COLUMN_W-1:0] base_col;
    logic [31:0]                   base_wide;
    logic                          at_bottom;
    logic                          is_bs;
    logic                          accept;
    logic                          push_req;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign push       = accept && push_req;

    assign col_inc   = {1'b0, col_reg} + 8'd1;
    assign line_inc  = {1'b0, line_reg} + 7'd1;
    assign col_dec   = col_reg - 7'd1;
    assign at_bottom = line_inc >= 7'(TEXT_LINES);
    assign is_bs     = (item.char_code == tcgr_pkg::CHAR_BS)
                    || (item.char_code == tcgr_pkg::CHAR_DEL);
    assign base_col  = is_bs ? col_dec : col_reg;
    assign base_wide = 32'(line_reg) * 32'(ROW_STRIDE) + 32'({base_col, 3'b000});

    always_comb
    begin
        col_next          = col_reg;
        line_next         = line_reg;
        push_req          = 1'b0;
        push_entry.cmd    = tcgr_pkg::CMD_DRAW;
        push_entry.glyph  = item.glyph_index;
        push_entry.row    = item.glyph_row;
        push_entry.bits   = item.glyph_bits;
        push_entry.base   = base_wide[tcgr_pkg::ADDR_W-1:0];
        push_entry.scroll = 1'b0;
        case (item.kind)
            tcgr_pkg::KIND_FONT:
            begin
                if (item.glyph_index < tcgr_pkg::GLYPH_COUNT)
                begin
                    push_req       = 1'b1;
                    push_entry.cmd = tcgr_pkg::CMD_FONT;
                end
            end
            tcgr_pkg::KIND_CLEAR:
            begin
                col_next       = '0;
                line_next      = '0;
                push_req       = 1'b1;
                push_entry.cmd = tcgr_pkg::CMD_CLEAR;
            end
            tcgr_pkg::KIND_PUT:
            begin
                case (item.char_code)
                    tcgr_pkg::CHAR_CR:
                    begin
                        col_next = '0;
                    end
                    tcgr_pkg::CHAR_LF:
                    begin
                        col_next = '0;
                        if (at_bottom)
                        begin
                            push_req       = 1'b1;
                            push_entry.cmd = tcgr_pkg::CMD_SCROLL;
                        end
                        else
                        begin
                            line_next = line_inc[tcgr_pkg::LINE_W-1:0];
                        end
                    end
                    tcgr_pkg::CHAR_BS, tcgr_pkg::CHAR_DEL:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next       = col_dec;
                            push_req       = 1'b1;
                            push_entry.cmd = tcgr_pkg::CMD_ERASE;
                        end
                    end
                    default:
                    begin
                        push_req       = 1'b1;
                        push_entry.cmd = tcgr_pkg::CMD_DRAW;
                        if (item.char_code inside {[tcgr_pkg::CHAR_FIRST:tcgr_pkg::CHAR_LAST]})
                        begin
                            push_entry.glyph = 7'(item.char_code - tcgr_pkg::CHAR_FIRST);
                        end
                        else
                        begin
                            push_entry.glyph = 7'(tcgr_pkg::CHAR_SUBST - tcgr_pkg::CHAR_FIRST);
                        end
                        if (col_inc >= 8'(TEXT_COLUMNS))
                        begin
                            col_next = '0;
                            if (at_bottom)
                            begin
                                push_entry.scroll = 1'b1;
                            end
                            else
                            begin
                                line_next = line_inc[tcgr_pkg::LINE_W-1:0];
                            end
                        end
                        else
                        begin
                            col_next = col_inc[tcgr_pkg::COLUMN_W-1:0];
                        end
                    end
                endcase
            end
            default:
            begin
                push_req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

FILE: src/tcgr_queue.sv
// Short command queue between the front end and the drawing back end.
`timescale 1ns / 1ps

module tcgr_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcgr_pkg::qentry_t push_entry,
    output logic              full,
    input  logic              pop,
    output tcgr_pkg::qhead_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcgr_pkg::qentry_t store_q [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = store_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_q[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/tcgr_back.sv
// Back end: glyph store, row sequencer, pixel expansion and result register.
`timescale 1ns / 1ps

module tcgr_back #(
    parameter int LINE_PIXELS = 640
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tcgr_pkg::qhead_t head,
    output logic             pop,
    tcgr_cfg_if.sink         cfg,
    tcgr_result_if.source    result
);

    logic [7:0] font_q [tcgr_pkg::FONT_DEPTH];

    logic [7:0]                    fg_reg;
    logic [7:0]                    bg_reg;
    logic [tcgr_pkg::STEP_W-1:0]   step_reg;
    logic [tcgr_pkg::STEP_W-1:0]   step_next;
    logic [tcgr_pkg::ADDR_W-1:0]   off_reg;
    logic [tcgr_pkg::ADDR_W-1:0]   off_next;

    logic                          uop_valid;
    logic [1:0]                    uop_op;
    logic [tcgr_pkg::ADDR_W-1:0]   uop_addr;
    logic                          uop_font;
    logic                          uop_final;
    logic [tcgr_pkg::FONT_AW-1:0]  rd_addr;
    logic [tcgr_pkg::FONT_AW-1:0]  wr_addr;
    logic                          mem_we;

    logic                          b_valid_reg;
    logic                          b_valid_next;
    logic [1:0]                    b_op_reg;
    logic [tcgr_pkg::ADDR_W-1:0]   b_addr_reg;
    logic                          b_font_reg;
    logic                          b_last_reg;
    logic [7:0]                    rd_data_reg;
    logic                          b_load;
    logic                          b_adv;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    out_op_reg;
    logic [tcgr_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [tcgr_pkg::PIXELS_W-1:0] out_pix_reg;
    logic                          out_last_reg;
    logic [tcgr_pkg::PIXELS_W-1:0] pix;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcgr_pkg::FG_RESET;
            bg_reg <= tcgr_pkg::BG_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tcgr_pkg::CFG_FG: fg_reg <= cfg.data;
                tcgr_pkg::CFG_BG: bg_reg <= cfg.data;
                default:          fg_reg <= fg_reg;
            endcase
        end
    end

    assign mem_we  = head.valid && (head.entry.cmd == tcgr_pkg::CMD_FONT);
    assign wr_addr = {head.entry.glyph, head.entry.row};
    assign rd_addr = {head.entry.glyph, step_reg[tcgr_pkg::ROW_W-1:0]};

    always_comb
    begin
        uop_valid = head.valid;
        uop_op    = tcgr_pkg::OP_WRITE;
        uop_addr  = head.entry.base + off_reg;
        uop_font  = 1'b0;
        uop_final = step_reg == tcgr_pkg::ROW_LAST_STEP;
        case (head.entry.cmd)
            tcgr_pkg::CMD_DRAW:
            begin
                if (step_reg == tcgr_pkg::SCROLL_STEP)
                begin
                    uop_op    = tcgr_pkg::OP_SCROLL;
                    uop_addr  = '0;
                    uop_final = 1'b1;
                end
                else
                begin
                    uop_font  = 1'b1;
                    uop_final = (step_reg == tcgr_pkg::ROW_LAST_STEP) && !head.entry.scroll;
                end
            end
            tcgr_pkg::CMD_ERASE:
            begin
                uop_op = tcgr_pkg::OP_WRITE;
            end
            tcgr_pkg::CMD_SCROLL:
            begin
                uop_op    = tcgr_pkg::OP_SCROLL;
                uop_addr  = '0;
                uop_final = 1'b1;
            end
            tcgr_pkg::CMD_CLEAR:
            begin
                uop_op    = tcgr_pkg::OP_CLEAR;
                uop_addr  = '0;
                uop_final = 1'b1;
            end
            default:
            begin
                uop_valid = 1'b0;
            end
        endcase
    end

    assign b_adv  = b_valid_reg && (!out_valid_reg || result.ready);
    assign b_load = uop_valid && (!b_valid_reg || b_adv);
    assign pop    = mem_we || (b_load && uop_final);

    always_comb
    begin
        step_next = step_reg;
        off_next  = off_reg;
        if (pop)
        begin
            step_next = '0;
            off_next  = '0;
        end
        else if (b_load)
        begin
            step_next = step_reg + 1'b1;
            off_next  = off_reg + tcgr_pkg::ADDR_W'(LINE_PIXELS);
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_load)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (b_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            if (b_font_reg && rd_data_reg[7 - c])
            begin
                pix[8*c +: 8] = fg_reg;
            end
            else
            begin
                pix[8*c +: 8] = bg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_q[wr_addr] <= head.entry.bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            rd_data_reg <= font_q[rd_addr];
            b_op_reg    <= uop_op;
            b_addr_reg  <= uop_addr;
            b_font_reg  <= uop_font;
            b_last_reg  <= uop_final;
        end
        if (b_adv)
        begin
            out_op_reg   <= b_op_reg;
            out_addr_reg <= b_addr_reg;
            out_pix_reg  <= pix;
            out_last_reg <= b_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            off_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            off_reg       <= off_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.op            = out_op_reg;
    assign result.pixel_address = out_addr_reg;
    assign result.pixels        = out_pix_reg;
    assign result.last          = out_last_reg;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= tcgr_pkg::SCROLL_STEP)
        else $error("row step beyond the scroll step");

    a_step_home: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == '0) && (off_reg == '0))
        else $error("sequencer not rewound after a command");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_adv |=> b_valid_reg && $stable(b_addr_reg) && $stable(b_op_reg))
        else $error("read stage lost its contents while stalled");

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && b_load))
        else $error("glyph store written while a row is read");
`endif

endmodule

FILE: src/text_console_glyph_renderer_top.sv
// Top level of the text console glyph renderer.
//
//   Channel   Direction  Transfer carries
//   item      in         kind, char_code, glyph_index, glyph_row, glyph_bits
//   result    out        op, pixel_address, pixels, last
//   cfg       in         index (0 foreground colour, 1 background colour), data
//
// A printable character is drawn as eight glyph rows in the back end, then a scroll when it wraps on the last line.
// Erase writes eight background rows; clear and scroll give one result each, and a font load gives none.
// The front end takes an item each cycle while the command queue has room.
// Reset clears the cursor, the queue and the pipeline; the glyph store holds no reset value.
// A stalled result holds the pipeline, and the queue then fills before item ready falls.
`timescale 1ns / 1ps

module text_console_glyph_renderer_top #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_LINES   = 60,
    parameter int LINE_PIXELS  = 640,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    tcgr_item_if.sink     item,
    tcgr_result_if.source result,
    tcgr_cfg_if.sink      cfg
);

    logic              q_full;
    logic              push;
    logic              pop;
    tcgr_pkg::qentry_t push_entry;
    tcgr_pkg::qhead_t  head;

    tcgr_front #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_LINES   (TEXT_LINES),
        .LINE_PIXELS  (LINE_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    tcgr_back #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg),
        .result (result)
    );

endmodule
